[design/eq3_pkg.sv]
`timescale 1ns / 1ps
package eq3_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 16;
  localparam int STATE_BITS     = 32;
  localparam int GUARD          = STATE_BITS - SAMPLE_BITS;
  localparam int GAIN_FRAC      = 12;
  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int FRAME_BITS     = 2 * SAMPLE_BITS;

  // shared multiplier: signed operand times unsigned 16-bit coefficient
  localparam int MUL_A_BITS = 41;
  localparam int MUL_P_BITS = MUL_A_BITS + REG_BITS;
  // band sum: three 33x16 products
  localparam int ACC_BITS   = 52;

  localparam int STEP_BITS  = 4;

  localparam logic [REG_BITS-1:0] LOW_POLE_RST    = 16'd63695;
  localparam logic [REG_BITS-1:0] HIGH_POLE_RST   = 16'd49287;
  localparam logic [REG_BITS-1:0] UNITY_GAIN      = 16'd4096;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_POLE    = 3'd0,
    REG_HIGH_POLE   = 3'd1,
    REG_LOW_GAIN    = 3'd2,
    REG_MID_GAIN    = 3'd3,
    REG_HIGH_GAIN   = 3'd4,
    REG_MASTER_GAIN = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [REG_BITS-1:0] low_pole;
    logic [REG_BITS-1:0] high_pole;
    logic [REG_BITS-1:0] low_gain;
    logic [REG_BITS-1:0] mid_gain;
    logic [REG_BITS-1:0] high_gain;
    logic [REG_BITS-1:0] master_gain;
  } cfg_t;

  typedef struct packed {
    logic                         issue;
    logic signed [MUL_A_BITS-1:0] a;
    logic [REG_BITS-1:0]          b;
  } mul_req_t;

endpackage

[design/eq3_cfg.sv]
`timescale 1ns / 1ps
module eq3_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [eq3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [eq3_pkg::REG_BITS-1:0]        cfg_data,
  output eq3_pkg::cfg_t                       regs
);
  import eq3_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_pole    <= LOW_POLE_RST;
      regs.high_pole   <= HIGH_POLE_RST;
      regs.low_gain    <= UNITY_GAIN;
      regs.mid_gain    <= UNITY_GAIN;
      regs.high_gain   <= UNITY_GAIN;
      regs.master_gain <= UNITY_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_POLE:    regs.low_pole    <= cfg_data;
        REG_HIGH_POLE:   regs.high_pole   <= cfg_data;
        REG_LOW_GAIN:    regs.low_gain    <= cfg_data;
        REG_MID_GAIN:    regs.mid_gain    <= cfg_data;
        REG_HIGH_GAIN:   regs.high_gain   <= cfg_data;
        REG_MASTER_GAIN: regs.master_gain <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

[design/eq3_mul.sv]
`timescale 1ns / 1ps
module eq3_mul (
  input  logic                                  clk,
  input  eq3_pkg::mul_req_t                     req,
  output logic signed [eq3_pkg::MUL_P_BITS-1:0] prod
);
  import eq3_pkg::*;

  logic signed [MUL_P_BITS:0] prod_full;

  // coefficient is unsigned: a zero above it keeps the product signed
  assign prod_full = req.a * $signed({1'b0, req.b});

  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod <= prod_full[MUL_P_BITS-1:0];
    end
  end

endmodule

[design/three_band_stereo_equalizer_core.sv]
`timescale 1ns / 1ps
// Three-band stereo equaliser with one-pole crossovers.
//
// s_axis carries one stereo frame per transfer, m_axis returns one equalised
// frame per input frame, in order. The cfg channel writes the pole and gain
// registers (index 0..5); it is always ready and should only be used while
// no frame is in flight. Unknown indices are ignored.
//
// Each frame runs from the input transfer through eight steps per channel,
// set by the one shared 41x16 multiplier, which is used six times per
// channel (two filter updates, three band gains, master gain), and then
// through the output register load in ST_DONE, which raises m_axis_tvalid.
// s_axis_tready is low while a frame is being worked on. The next frame is
// taken in the same cycle the result is loaded; one frame is worked on at a time.
// If the receiver stalls, the finished frame waits and no new input is taken
// until the output register is free; nothing is dropped.
// Reset clears the four filter states to zero, restores the register
// defaults and empties the output register.
module three_band_stereo_equalizer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] left_in, [47:24] right_in
  input  logic [eq3_pkg::FRAME_BITS-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [23:0] left_out, [47:24] right_out
  output logic [eq3_pkg::FRAME_BITS-1:0]      m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [eq3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [eq3_pkg::REG_BITS-1:0]        cfg_data
);
  import eq3_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // steps within one channel
  localparam logic [2:0] PH_LO_FILT = 3'd0;
  localparam logic [2:0] PH_HI_FILT = 3'd1;
  localparam logic [2:0] PH_LO_GAIN = 3'd2;
  localparam logic [2:0] PH_MID_GAIN = 3'd3;
  localparam logic [2:0] PH_HI_GAIN = 3'd4;
  localparam logic [2:0] PH_ROUND = 3'd5;
  localparam logic [2:0] PH_MASTER = 3'd6;
  localparam logic [2:0] PH_SAT = 3'd7;

  localparam logic [STEP_BITS-1:0] LAST_STEP = '1;

  localparam logic signed [MUL_P_BITS-1:0] FILT_RND = MUL_P_BITS'(1) << (COEF_BITS - 1);
  localparam logic signed [ACC_BITS-1:0]   ACC_RND  = ACC_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic signed [MUL_P_BITS-1:0] OUT_RND  =
    MUL_P_BITS'(1) << (GAIN_FRAC + GUARD - 1);
  localparam logic signed [MUL_P_BITS-1:0] SMAX = (MUL_P_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [MUL_P_BITS-1:0] SMIN = -(MUL_P_BITS'(1) << (SAMPLE_BITS - 1));

  cfg_t     regs;
  mul_req_t mreq;
  logic signed [MUL_P_BITS-1:0] prod;

  state_t                 state;
  logic [STEP_BITS-1:0]   step;
  logic                   ch;
  logic [2:0]             phase;

  logic signed [SAMPLE_BITS-1:0] x_left, x_right, x_cur;
  logic signed [STATE_BITS-1:0]  lo_left, lo_right, hi_left, hi_right;
  logic signed [STATE_BITS-1:0]  lo_cur, hi_cur, xs;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [MUL_A_BITS-1:0]  accr;
  logic signed [SAMPLE_BITS-1:0] y_left, y_right;

  logic signed [MUL_P_BITS-1:0]  filt_sum, filt_sh, y_sum, y_sh;
  logic [STATE_BITS-1:0]         filt_new;
  logic signed [ACC_BITS-1:0]    prod_acc, acc_sum, acc_rnd;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          s_accept, out_free;

  eq3_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  eq3_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign ch    = step[STEP_BITS-1];
  assign phase = step[2:0];

  assign x_cur  = ch ? x_right : x_left;
  assign lo_cur = ch ? lo_right : lo_left;
  assign hi_cur = ch ? hi_right : hi_left;
  assign xs     = {x_cur, {GUARD{1'b0}}};

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) || (state == ST_DONE && out_free);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // s' = x + round(p * (s - x)), the convex form of the one-pole update
  assign filt_sum = prod + FILT_RND;
  assign filt_sh  = filt_sum >>> COEF_BITS;
  assign filt_new = xs + filt_sh[STATE_BITS-1:0];

  assign prod_acc = $signed(prod[ACC_BITS-1:0]);
  assign acc_sum  = acc + prod_acc;
  assign acc_rnd  = (acc_sum + ACC_RND) >>> GAIN_FRAC;

  assign y_sum = prod + OUT_RND;
  assign y_sh  = y_sum >>> (GAIN_FRAC + GUARD);

  always_comb begin
    if (y_sh > SMAX) begin
      y_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (y_sh < SMIN) begin
      y_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_sh[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    mreq.issue = (state == ST_RUN) && (phase != PH_ROUND) && (phase != PH_SAT);
    mreq.a     = '0;
    mreq.b     = '0;
    case (phase)
      PH_LO_FILT: begin
        mreq.a = MUL_A_BITS'(lo_cur) - MUL_A_BITS'(xs);
        mreq.b = regs.low_pole;
      end
      PH_HI_FILT: begin
        mreq.a = MUL_A_BITS'(hi_cur) - MUL_A_BITS'(xs);
        mreq.b = regs.high_pole;
      end
      PH_LO_GAIN: begin
        mreq.a = MUL_A_BITS'(lo_cur);
        mreq.b = regs.low_gain;
      end
      PH_MID_GAIN: begin
        mreq.a = MUL_A_BITS'(hi_cur) - MUL_A_BITS'(lo_cur);
        mreq.b = regs.mid_gain;
      end
      PH_HI_GAIN: begin
        mreq.a = MUL_A_BITS'(xs) - MUL_A_BITS'(hi_cur);
        mreq.b = regs.high_gain;
      end
      PH_MASTER: begin
        mreq.a = accr;
        mreq.b = regs.master_gain;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
      lo_left       <= '0;
      lo_right      <= '0;
      hi_left       <= '0;
      hi_right      <= '0;
    end else begin
      // in ST_DONE the output register is reloaded below
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            x_left  <= s_axis_tdata[SAMPLE_BITS-1:0];
            x_right <= s_axis_tdata[FRAME_BITS-1:SAMPLE_BITS];
            step    <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          case (phase)
            PH_HI_FILT: begin
              if (ch) lo_right <= filt_new;
              else    lo_left  <= filt_new;
            end
            PH_LO_GAIN: begin
              if (ch) hi_right <= filt_new;
              else    hi_left  <= filt_new;
            end
            PH_MID_GAIN: acc <= prod_acc;
            PH_HI_GAIN:  acc <= acc_sum;
            PH_ROUND:    accr <= MUL_A_BITS'(acc_rnd);
            PH_SAT: begin
              if (ch) y_right <= y_sat;
              else    y_left  <= y_sat;
            end
            default: ;
          endcase
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= {y_right, y_left};
            m_axis_tvalid <= 1'b1;
            if (s_accept) begin
              x_left  <= s_axis_tdata[SAMPLE_BITS-1:0];
              x_right <= s_axis_tdata[FRAME_BITS-1:SAMPLE_BITS];
              step    <= '0;
              state   <= ST_RUN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_RUN && step == '0))
    else $error("accepted frame did not start the sequence");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == LAST_STEP) |=> (state == ST_DONE))
    else $error("sequence did not finish after the last step");

  a_no_mul_on_idle_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && (phase == PH_ROUND || phase == PH_SAT)) |-> !mreq.issue)
    else $error("multiplier issued on a step that consumes its product");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented outside the completion step");

endmodule
